// ===== sv/prsi_pkg.sv =====
// Package for the partition range start index unit.
// Holds sizes, field codes and the command and status structs; used by all modules.
// Depends on nothing.
`default_nettype none

package prsi_pkg;

    localparam int MAX_PARTS   = 32;
    localparam int LOCAL_WIDTH = 31;
    localparam int IDX_W       = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

    localparam int GIDX_W  = 63;
    localparam int PART_W  = 6;
    localparam int CFG_W   = 7;
    localparam int EMPTY_W = 7;
    localparam int STAT_W  = 2;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam logic [LOCAL_WIDTH-1:0] LOCAL_MAX = {LOCAL_WIDTH{1'b1}};
    localparam logic [CFG_W-1:0] PARTS_MAX = CFG_W'(MAX_PARTS);
    localparam logic [CFG_W-1:0] PART_COUNT_RESET = CFG_W'(1);

    localparam logic [0:0] REG_PART_COUNT = 1'b0;

    localparam logic CMD_RANGE  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_SIZE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_PART  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_ORDER = 2'd2;
    localparam logic [STAT_W-1:0] ST_SATURATED = 2'd3;

    typedef struct packed {
        logic capture;
        logic check;
        logic load_range;
        logic load_part;
        logic clear_sums;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic walk_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/prsi_regs.sv =====
// Configuration register file of the partition range start index unit.
// APB-style write and read of the part count; uses prsi_pkg.
`default_nettype none

module prsi_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [prsi_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [prsi_pkg::DATA_W-1:0]  pwdata,
    output logic      [prsi_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output logic      [prsi_pkg::CFG_W-1:0]   part_count
);
    import prsi_pkg::*;

    logic [CFG_W-1:0] part_count_reg;
    logic [CFG_W-1:0] part_count_next;
    logic             addr_hit;

    assign addr_hit = (paddr[ADDR_W-1:2] == REG_PART_COUNT);
    assign pready   = 1'b1;

    always_comb
    begin
        part_count_next = part_count_reg;
        if (psel && penable && pwrite && addr_hit)
        begin
            part_count_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_count_reg <= PART_COUNT_RESET;
        end
        else
        begin
            part_count_reg <= part_count_next;
        end
    end

    assign prdata     = (psel && addr_hit) ? DATA_W'(part_count_reg) : '0;
    assign part_count = part_count_reg;

endmodule

`default_nettype wire

// ===== sv/prsi_ctrl.sv =====
// Controller of the partition range start index unit.
// Sequences input capture, range check, table update and the finish walk; uses prsi_pkg.
`default_nettype none

module prsi_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic                 command,
    input  wire prsi_pkg::dp_status_t dp_status,
    output prsi_pkg::ctrl_cmd_t       ctrl_cmd
);
    import prsi_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_WALK   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl_cmd   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    ctrl_cmd.capture = 1'b1;
                    state_next = (command == CMD_FINISH) ? S_WALK : S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctrl_cmd.check = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (dp_status.out_free)
                begin
                    ctrl_cmd.load_range = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (dp_status.out_free)
                begin
                    ctrl_cmd.load_part = 1'b1;
                    if (dp_status.walk_last)
                    begin
                        ctrl_cmd.clear_sums = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/prsi_dpath.sv =====
// Datapath of the partition range start index unit.
// Holds the per-part sum table, range arithmetic, finish walk and result register; uses prsi_pkg.
`default_nettype none

module prsi_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire prsi_pkg::ctrl_cmd_t               ctrl_cmd,
    output prsi_pkg::dp_status_t                   dp_status,
    input  wire logic [prsi_pkg::CFG_W-1:0]        part_count,
    input  wire logic [prsi_pkg::GIDX_W-1:0]       range_begin,
    input  wire logic [prsi_pkg::GIDX_W-1:0]       range_end,
    input  wire logic [prsi_pkg::PART_W-1:0]       range_part,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic                                   kind,
    output logic      [prsi_pkg::LOCAL_WIDTH-1:0]  start_index,
    output logic      [prsi_pkg::PART_W-1:0]       part_id,
    output logic      [prsi_pkg::LOCAL_WIDTH-1:0]  part_size,
    output logic      [prsi_pkg::EMPTY_W-1:0]      empty_parts,
    output logic      [prsi_pkg::STAT_W-1:0]       status,
    output logic                                   last
);
    import prsi_pkg::*;

    logic [LOCAL_WIDTH-1:0] sums_reg [MAX_PARTS];

    logic [GIDX_W-1:0]      begin_reg;
    logic [GIDX_W-1:0]      end_reg;
    logic [PART_W-1:0]      part_reg;
    logic [LOCAL_WIDTH-1:0] size_lo_reg;
    logic                   size_big_reg;
    logic                   bad_part_reg;
    logic                   bad_order_reg;
    logic [LOCAL_WIDTH-1:0] start_reg;
    logic [IDX_W-1:0]       walk_cnt_reg;
    logic [EMPTY_W-1:0]     empty_reg;

    logic                   out_valid_reg;
    logic                   kind_reg;
    logic [LOCAL_WIDTH-1:0] start_index_reg;
    logic [PART_W-1:0]      part_id_reg;
    logic [LOCAL_WIDTH-1:0] part_size_reg;
    logic [EMPTY_W-1:0]     empty_parts_reg;
    logic [STAT_W-1:0]      status_reg;
    logic                   last_reg;

    logic [CFG_W-1:0]       parts_used;
    logic [IDX_W-1:0]       last_idx;
    logic [GIDX_W:0]        diff;
    logic [LOCAL_WIDTH:0]   sum;
    logic                   sat;
    logic [LOCAL_WIDTH-1:0] sum_clamped;
    logic                   range_ok;
    logic [LOCAL_WIDTH-1:0] walk_sum;
    logic [EMPTY_W-1:0]     empty_next;
    logic                   walk_last;
    logic [STAT_W-1:0]      range_status;

    always_comb
    begin
        if (part_count == '0)
        begin
            parts_used = CFG_W'(1);
        end
        else if (part_count > PARTS_MAX)
        begin
            parts_used = PARTS_MAX;
        end
        else
        begin
            parts_used = part_count;
        end
    end

    assign last_idx    = IDX_W'(parts_used - CFG_W'(1));
    assign diff        = {1'b0, end_reg} - {1'b0, begin_reg};
    assign sum         = {1'b0, start_reg} + {1'b0, size_lo_reg};
    assign sat         = size_big_reg | sum[LOCAL_WIDTH];
    assign sum_clamped = sat ? LOCAL_MAX : sum[LOCAL_WIDTH-1:0];
    assign range_ok    = !bad_part_reg && !bad_order_reg;
    assign walk_sum    = sums_reg[walk_cnt_reg];
    assign empty_next  = empty_reg + EMPTY_W'(walk_sum == '0);
    assign walk_last   = (walk_cnt_reg == last_idx);

    always_comb
    begin
        if (bad_part_reg)
        begin
            range_status = ST_BAD_PART;
        end
        else if (bad_order_reg)
        begin
            range_status = ST_BAD_ORDER;
        end
        else if (sat)
        begin
            range_status = ST_SATURATED;
        end
        else
        begin
            range_status = ST_OK;
        end
    end

    assign dp_status.out_free  = !out_valid_reg || result_ready;
    assign dp_status.walk_last = walk_last;

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.capture)
        begin
            begin_reg <= range_begin;
            end_reg   <= range_end;
            part_reg  <= range_part;
        end
        if (ctrl_cmd.check)
        begin
            size_lo_reg   <= diff[LOCAL_WIDTH-1:0];
            size_big_reg  <= |diff[GIDX_W-1:LOCAL_WIDTH];
            bad_order_reg <= diff[GIDX_W];
            bad_part_reg  <= (CFG_W'(part_reg) >= parts_used);
            start_reg     <= sums_reg[part_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PARTS; i++)
            begin
                sums_reg[i] <= '0;
            end
            walk_cnt_reg <= '0;
            empty_reg    <= '0;
        end
        else
        begin
            if (ctrl_cmd.capture)
            begin
                walk_cnt_reg <= '0;
                empty_reg    <= '0;
            end
            else if (ctrl_cmd.load_part)
            begin
                walk_cnt_reg <= walk_cnt_reg + IDX_W'(1);
                empty_reg    <= empty_next;
            end
            if (ctrl_cmd.clear_sums)
            begin
                for (int i = 0; i < MAX_PARTS; i++)
                begin
                    sums_reg[i] <= '0;
                end
            end
            else if (ctrl_cmd.load_range && range_ok)
            begin
                sums_reg[part_reg[IDX_W-1:0]] <= sum_clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl_cmd.load_range || ctrl_cmd.load_part)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load_range)
        begin
            kind_reg        <= KIND_START;
            start_index_reg <= range_ok ? start_reg : '0;
            part_id_reg     <= '0;
            part_size_reg   <= '0;
            empty_parts_reg <= '0;
            status_reg      <= range_status;
            last_reg        <= 1'b1;
        end
        else if (ctrl_cmd.load_part)
        begin
            kind_reg        <= KIND_SIZE;
            start_index_reg <= '0;
            part_id_reg     <= PART_W'(walk_cnt_reg);
            part_size_reg   <= walk_sum;
            empty_parts_reg <= walk_last ? empty_next : '0;
            status_reg      <= ST_OK;
            last_reg        <= walk_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign start_index  = start_index_reg;
    assign part_id      = part_id_reg;
    assign part_size    = part_size_reg;
    assign empty_parts  = empty_parts_reg;
    assign status       = status_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== sv/partition_range_start_indices_unit.sv =====
// A range beat passes capture, check and update: the accepting edge captures it, the check
// step takes the difference of the 63-bit bounds, checks the part and reads the sum table, and
// the update step adds with saturation, writes the per-part sum table and registers the result.
// A finish beat is captured and then walks the parts in use, reading one table entry per cycle
// while the output is free. The result register lets the next beat be accepted while a result
// waits, but a stalled output holds the update or walk step that follows. There is no clearing
// pass: the sum table is cleared together with the last walk step.
// Top level of the partition range start index unit; instantiates prsi_regs, prsi_ctrl
// and prsi_dpath, and uses prsi_pkg.
`default_nettype none

module partition_range_start_indices_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [prsi_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [prsi_pkg::DATA_W-1:0]       pwdata,
    output logic      [prsi_pkg::DATA_W-1:0]       prdata,
    output logic                                   pready,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic                              command,
    input  wire logic [prsi_pkg::GIDX_W-1:0]       range_begin,
    input  wire logic [prsi_pkg::GIDX_W-1:0]       range_end,
    input  wire logic [prsi_pkg::PART_W-1:0]       range_part,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic                                   kind,
    output logic      [prsi_pkg::LOCAL_WIDTH-1:0]  start_index,
    output logic      [prsi_pkg::PART_W-1:0]       part_id,
    output logic      [prsi_pkg::LOCAL_WIDTH-1:0]  part_size,
    output logic      [prsi_pkg::EMPTY_W-1:0]      empty_parts,
    output logic      [prsi_pkg::STAT_W-1:0]       status,
    output logic                                   last
);
    import prsi_pkg::*;

    logic [CFG_W-1:0] part_count;
    ctrl_cmd_t        ctrl_cmd;
    dp_status_t       dp_status;

    prsi_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .part_count (part_count)
    );

    prsi_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .command    (command),
        .dp_status  (dp_status),
        .ctrl_cmd   (ctrl_cmd)
    );

    prsi_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl_cmd     (ctrl_cmd),
        .dp_status    (dp_status),
        .part_count   (part_count),
        .range_begin  (range_begin),
        .range_end    (range_end),
        .range_part   (range_part),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .start_index  (start_index),
        .part_id      (part_id),
        .part_size    (part_size),
        .empty_parts  (empty_parts),
        .status       (status),
        .last         (last)
    );

endmodule

`default_nettype wire
